// ----- rtl/core/psch_pkg.sv -----
package psch_pkg;

  // Default depth of the process table
  localparam int unsigned MaxProcsDef = 16;

  // Field widths
  localparam int unsigned TimeInW = 16;  // arrival and burst on the input side
  localparam int unsigned PrioW   = 8;
  localparam int unsigned TimeW   = 24;  // simulated clock, waiting, turnaround
  localparam int unsigned SumW    = 28;
  localparam int unsigned IdxOutW = 4;

  // One row of the process table
  typedef struct packed {
    logic [TimeInW-1:0] arrival;
    logic [TimeInW-1:0] burst;
    logic [PrioW-1:0]   prio;
    logic [TimeInW-1:0] remaining;
  } proc_entry_t;

  // One row of the result table
  typedef struct packed {
    logic [TimeW-1:0] waiting;
    logic [TimeW-1:0] turnaround;
  } proc_result_t;

  // What one pass over the table found
  typedef struct packed {
    logic               have_best;
    logic               have_next;
    logic [TimeInW-1:0] next_arrival;
    proc_entry_t        best;
  } scan_status_t;

endpackage

// ----- rtl/core/psch_in_if.sv -----
interface psch_in_if;
  import psch_pkg::*;

  logic               valid;
  logic               ready;
  logic [TimeInW-1:0] arrival_time;
  logic [TimeInW-1:0] burst_time;
  logic [PrioW-1:0]   priority_level;
  logic               last;

  modport source (
    output valid, arrival_time, burst_time, priority_level, last,
    input  ready
  );

  modport sink (
    input  valid, arrival_time, burst_time, priority_level, last,
    output ready
  );
endinterface

// ----- rtl/core/psch_out_if.sv -----
interface psch_out_if;
  import psch_pkg::*;

  logic               valid;
  logic               ready;
  logic [IdxOutW-1:0] process_index;
  logic [TimeW-1:0]   waiting_time;
  logic [TimeW-1:0]   turnaround_time;
  logic [SumW-1:0]    total_waiting;
  logic [SumW-1:0]    total_turnaround;
  logic               last_res;

  modport source (
    output valid, process_index, waiting_time, turnaround_time,
           total_waiting, total_turnaround, last_res,
    input  ready
  );

  modport sink (
    input  valid, process_index, waiting_time, turnaround_time,
           total_waiting, total_turnaround, last_res,
    output ready
  );
endinterface

// ----- rtl/core/preemptive_priority_scheduler_core.sv -----
// Channel   Dir  Handshake      Payload
// -------   ---  -------------  ------------------------------------------------
// in_i      in   valid/ready    arrival_time, burst_time, priority_level, last
// out_o     out  valid/ready    process_index, waiting_time, turnaround_time,
//                               total_waiting, total_turnaround, last_res
// cfg       in   cfg_we_i       cfg_wdata_i = order_mode
//
// Process beats are taken back to back while the sequencer is in ST_LOAD. After
// the last beat the scheduler runs event by event: each decision is one pass over
// the process table RAM, one row read per cycle, and a completion adds the
// ST_TAT, ST_WT and ST_SUM states. Results stream one per cycle while out_o is
// ready, after ST_EREAD fetches the first row. rst_ni clears all control state;
// the RAMs are not cleared. Input is stalled from the last beat until the final
// result beat is taken; a stall on out_o holds the result in the RAM read register.
module preemptive_priority_scheduler_core #(
  parameter int unsigned MAX_PROCS = psch_pkg::MaxProcsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  psch_in_if.sink     in_i,
  psch_out_if.source  out_o
);
  import psch_pkg::*;

  localparam int unsigned IdxW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int unsigned CntW = $clog2(MAX_PROCS + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(MAX_PROCS);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);
  localparam logic [TimeW-1:0] TimeMax = '1;
  localparam logic [SumW-1:0]  SumMax  = '1;

  // Sequencer states
  localparam logic [3:0] ST_LOAD  = 4'd0;  // take process beats
  localparam logic [3:0] ST_SCAN  = 4'd1;  // sweep the table, pick best and next arrival
  localparam logic [3:0] ST_STEP  = 4'd2;  // idle jump or size the run
  localparam logic [3:0] ST_ADV   = 4'd3;  // advance time, write back remaining
  localparam logic [3:0] ST_TAT   = 4'd4;  // turnaround of the finished process
  localparam logic [3:0] ST_WT    = 4'd5;  // waiting time, turnaround sum
  localparam logic [3:0] ST_SUM   = 4'd6;  // waiting sum, store results, mark done
  localparam logic [3:0] ST_EREAD = 4'd7;  // fetch the first result
  localparam logic [3:0] ST_EOUT  = 4'd8;  // present results

  logic [3:0]           state_q, state_d;
  logic                 order_mode_q, order_mode_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [CntW-1:0]      fin_q, fin_d;
  logic [CntW-1:0]      scan_cnt_q, scan_cnt_d;
  logic [CntW-1:0]      emit_idx_q, emit_idx_d;
  logic                 rd_vld_q, rd_vld_d;
  logic [IdxW-1:0]      rd_idx_q, rd_idx_d;
  logic [MAX_PROCS-1:0] done_q, done_d;
  logic [TimeW-1:0]     now_q, now_d;
  logic [SumW-1:0]      wait_sum_q, wait_sum_d;
  logic [SumW-1:0]      turn_sum_q, turn_sum_d;
  logic [TimeInW-1:0]   run_q, run_d;
  logic [TimeW-1:0]     tat_q, tat_d;
  logic [TimeW-1:0]     wt_q, wt_d;

  // Process table RAM
  logic            p_we, p_re;
  logic [IdxW-1:0] p_waddr, p_raddr;
  proc_entry_t     p_wdata, p_rdata;

  // Result table RAM
  logic            r_we, r_re;
  logic [IdxW-1:0] r_waddr, r_raddr;
  proc_result_t    r_wdata, r_rdata;

  logic            scan_clr;
  scan_status_t    scan_st;
  logic [IdxW-1:0] best_idx;

  logic               in_acc, out_acc;
  logic [TimeInW-1:0] load_burst;
  logic [TimeW-1:0]   gap;
  logic [TimeInW-1:0] run_sel;
  logic [TimeW:0]     now_sum;
  logic [TimeW-1:0]   now_adv;
  logic [TimeInW-1:0] rem_new;
  logic [TimeW-1:0]   tat_new, wt_new;
  logic [SumW:0]      turn_add, wait_add;
  logic [CntW-1:0]    emit_next;
  logic               emit_last;

  psch_ram #(
    .Width($bits(proc_entry_t)),
    .Depth(MAX_PROCS)
  ) u_proc_ram (
    .clk_i  (clk_i),
    .we_i   (p_we),
    .waddr_i(p_waddr),
    .wdata_i(p_wdata),
    .re_i   (p_re),
    .raddr_i(p_raddr),
    .rdata_o(p_rdata)
  );

  psch_ram #(
    .Width($bits(proc_result_t)),
    .Depth(MAX_PROCS)
  ) u_res_ram (
    .clk_i  (clk_i),
    .we_i   (r_we),
    .waddr_i(r_waddr),
    .wdata_i(r_wdata),
    .re_i   (r_re),
    .raddr_i(r_raddr),
    .rdata_o(r_rdata)
  );

  psch_scan #(
    .IdxW(IdxW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (scan_clr),
    .rd_vld_i    (rd_vld_q),
    .rd_idx_i    (rd_idx_q),
    .rd_entry_i  (p_rdata),
    .rd_done_i   (done_q[rd_idx_q]),
    .now_i       (now_q),
    .order_mode_i(order_mode_q),
    .status_o    (scan_st),
    .best_idx_o  (best_idx)
  );

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  // Datapath terms; each feeds at most one adder before a register
  always_comb begin
    // treat a zero burst as one unit
    load_burst = (in_i.burst_time == '0) ? TimeInW'(1) : in_i.burst_time;

    // run until completion or until the next arrival may preempt
    gap     = TimeW'(scan_st.next_arrival) - now_q;
    run_sel = (scan_st.have_next && (gap < TimeW'(scan_st.best.remaining)))
              ? gap[TimeInW-1:0] : scan_st.best.remaining;

    now_sum = {1'b0, now_q} + (TimeW + 1)'(run_q);
    now_adv = now_sum[TimeW] ? TimeMax : now_sum[TimeW-1:0];
    rem_new = scan_st.best.remaining - run_q;

    tat_new = now_q - TimeW'(scan_st.best.arrival);
    wt_new  = (tat_q > TimeW'(scan_st.best.burst))
              ? (tat_q - TimeW'(scan_st.best.burst)) : '0;

    turn_add = {1'b0, turn_sum_q} + (SumW + 1)'(tat_q);
    wait_add = {1'b0, wait_sum_q} + (SumW + 1)'(wt_q);

    emit_next = emit_idx_q + CntOne;
    emit_last = (emit_next == cnt_q);
  end

  // Sequencer
  always_comb begin
    state_d      = state_q;
    order_mode_d = cfg_we_i ? cfg_wdata_i : order_mode_q;
    cnt_d        = cnt_q;
    fin_d        = fin_q;
    scan_cnt_d   = scan_cnt_q;
    emit_idx_d   = emit_idx_q;
    rd_vld_d     = 1'b0;
    rd_idx_d     = rd_idx_q;
    done_d       = done_q;
    now_d        = now_q;
    wait_sum_d   = wait_sum_q;
    turn_sum_d   = turn_sum_q;
    run_d        = run_q;
    tat_d        = tat_q;
    wt_d         = wt_q;

    p_we    = 1'b0;
    p_waddr = '0;
    p_wdata = scan_st.best;
    p_re    = 1'b0;
    p_raddr = scan_cnt_q[IdxW-1:0];
    r_we    = 1'b0;
    r_waddr = best_idx;
    r_wdata = '{waiting: wt_q, turnaround: tat_q};
    r_re    = 1'b0;
    r_raddr = emit_idx_q[IdxW-1:0];

    unique case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          // drop beats once the table is full
          if (cnt_q != CntFull) begin
            p_we    = 1'b1;
            p_waddr = cnt_q[IdxW-1:0];
            p_wdata = '{arrival:   in_i.arrival_time,
                        burst:     load_burst,
                        prio:      in_i.priority_level,
                        remaining: load_burst};
            done_d[cnt_q[IdxW-1:0]] = 1'b0;
            cnt_d   = cnt_q + CntOne;
          end
          if (in_i.last && (cnt_d != '0)) begin
            state_d    = ST_SCAN;
            now_d      = '0;
            fin_d      = '0;
            wait_sum_d = '0;
            turn_sum_d = '0;
          end
        end
      end

      ST_SCAN: begin
        if (scan_cnt_q != cnt_q) begin
          // issue one row read per cycle
          p_re       = 1'b1;
          rd_vld_d   = 1'b1;
          rd_idx_d   = scan_cnt_q[IdxW-1:0];
          scan_cnt_d = scan_cnt_q + CntOne;
        end else if (!rd_vld_q) begin
          state_d = ST_STEP;
        end
      end

      ST_STEP: begin
        if (!scan_st.have_best) begin
          // nothing ready: jump to the next arrival
          now_d   = TimeW'(scan_st.next_arrival);
          state_d = ST_SCAN;
        end else begin
          run_d   = run_sel;
          state_d = ST_ADV;
        end
      end

      ST_ADV: begin
        now_d             = now_adv;
        p_we              = 1'b1;
        p_waddr           = best_idx;
        p_wdata.remaining = rem_new;
        state_d           = (rem_new == '0) ? ST_TAT : ST_SCAN;
      end

      ST_TAT: begin
        tat_d   = tat_new;
        state_d = ST_WT;
      end

      ST_WT: begin
        wt_d       = wt_new;
        turn_sum_d = turn_add[SumW] ? SumMax : turn_add[SumW-1:0];
        state_d    = ST_SUM;
      end

      ST_SUM: begin
        wait_sum_d       = wait_add[SumW] ? SumMax : wait_add[SumW-1:0];
        r_we             = 1'b1;
        done_d[best_idx] = 1'b1;
        fin_d            = fin_q + CntOne;
        if ((fin_q + CntOne) == cnt_q) begin
          emit_idx_d = '0;
          state_d    = ST_EREAD;
        end else begin
          state_d = ST_SCAN;
        end
      end

      ST_EREAD: begin
        r_re    = 1'b1;
        state_d = ST_EOUT;
      end

      ST_EOUT: begin
        if (out_acc) begin
          if (emit_last) begin
            // set delivered: reopen for loading
            cnt_d   = '0;
            fin_d   = '0;
            done_d  = '0;
            state_d = ST_LOAD;
          end else begin
            // fetch the next row on the same edge the beat leaves
            emit_idx_d = emit_next;
            r_re       = 1'b1;
            r_raddr    = emit_next[IdxW-1:0];
          end
        end
      end

      default: begin
        state_d = ST_LOAD;
      end
    endcase

    // restart the sweep whenever a pass begins
    scan_clr = (state_d == ST_SCAN) && (state_q != ST_SCAN);
    if (scan_clr) begin
      scan_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_LOAD;
      order_mode_q <= 1'b0;
      cnt_q        <= '0;
      fin_q        <= '0;
      scan_cnt_q   <= '0;
      emit_idx_q   <= '0;
      rd_vld_q     <= 1'b0;
      done_q       <= '0;
      now_q        <= '0;
      wait_sum_q   <= '0;
      turn_sum_q   <= '0;
    end else begin
      state_q      <= state_d;
      order_mode_q <= order_mode_d;
      cnt_q        <= cnt_d;
      fin_q        <= fin_d;
      scan_cnt_q   <= scan_cnt_d;
      emit_idx_q   <= emit_idx_d;
      rd_vld_q     <= rd_vld_d;
      done_q       <= done_d;
      now_q        <= now_d;
      wait_sum_q   <= wait_sum_d;
      turn_sum_q   <= turn_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= rd_idx_d;
    run_q    <= run_d;
    tat_q    <= tat_d;
    wt_q     <= wt_d;
  end

  // Ports
  assign in_i.ready             = (state_q == ST_LOAD);
  assign out_o.valid            = (state_q == ST_EOUT);
  assign out_o.process_index    = IdxOutW'(emit_idx_q);
  assign out_o.waiting_time     = r_rdata.waiting;
  assign out_o.turnaround_time  = r_rdata.turnaround;
  assign out_o.total_waiting    = emit_last ? wait_sum_q : '0;
  assign out_o.total_turnaround = emit_last ? turn_sum_q : '0;
  assign out_o.last_res         = emit_last;

  // Checks
  a_fin_le_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q <= cnt_q)
    else $error("finished count exceeds loaded count");

  a_idle_has_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_STEP && !scan_st.have_best) |-> scan_st.have_next)
    else $error("no ready process and no pending arrival");

  a_run_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADV) |-> (run_q != '0))
    else $error("scheduling step makes no progress");

  a_emit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (emit_idx_q < cnt_q))
    else $error("result index beyond loaded set");

endmodule

// ----- rtl/core/psch_ram.sv -----
module psch_ram #(
  parameter  int unsigned Width = 8,
  parameter  int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- rtl/core/psch_scan.sv -----
module psch_scan #(
  parameter int unsigned IdxW = 4
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        clear_i,
  input  logic                        rd_vld_i,
  input  logic [IdxW-1:0]             rd_idx_i,
  input  psch_pkg::proc_entry_t       rd_entry_i,
  input  logic                        rd_done_i,
  input  logic [psch_pkg::TimeW-1:0]  now_i,
  input  logic                        order_mode_i,
  output psch_pkg::scan_status_t      status_o,
  output logic [IdxW-1:0]             best_idx_o
);
  import psch_pkg::*;

  logic               have_best_q, have_best_d;
  logic               have_next_q, have_next_d;
  logic [TimeInW-1:0] next_q;
  proc_entry_t        best_q;
  logic [IdxW-1:0]    best_idx_q;

  logic arrived, prio_wins, beats, take_best, take_next;

  always_comb begin
    arrived   = TimeW'(rd_entry_i.arrival) <= now_i;
    prio_wins = order_mode_i ? (rd_entry_i.prio > best_q.prio)
                             : (rd_entry_i.prio < best_q.prio);
    // equal priority: earlier arrival wins, equal arrival keeps the lower index
    beats     = (rd_entry_i.prio != best_q.prio) ? prio_wins
                                                 : (rd_entry_i.arrival < best_q.arrival);
    take_best = rd_vld_i && !rd_done_i && arrived && (!have_best_q || beats);
    take_next = rd_vld_i && !rd_done_i && !arrived &&
                (!have_next_q || (rd_entry_i.arrival < next_q));

    have_best_d = clear_i ? 1'b0 : (have_best_q || take_best);
    have_next_d = clear_i ? 1'b0 : (have_next_q || take_next);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_best_q <= 1'b0;
      have_next_q <= 1'b0;
    end else begin
      have_best_q <= have_best_d;
      have_next_q <= have_next_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_best) begin
      best_q     <= rd_entry_i;
      best_idx_q <= rd_idx_i;
    end
    if (take_next) begin
      next_q <= rd_entry_i.arrival;
    end
  end

  assign status_o.have_best    = have_best_q;
  assign status_o.have_next    = have_next_q;
  assign status_o.next_arrival = next_q;
  assign status_o.best         = best_q;
  assign best_idx_o            = best_idx_q;
endmodule

// ----- sim/tb_preemptive_priority_scheduler_core.sv -----
module tb_preemptive_priority_scheduler_core;
  timeunit 1ns;
  timeprecision 1ps;

  import psch_pkg::*;

  // Clock, reset and run length
  localparam int unsigned ClkHighNs      = 6;
  localparam int unsigned ClkLowNs       = 6;
  localparam int unsigned ResetCycles    = 12;
  localparam int unsigned WatchdogNs     = 8_000_000;
  // Stimulus shape
  localparam int unsigned TableDepth     = MaxProcsDef;
  localparam int unsigned RandomProcs    = 420;
  localparam int unsigned LongHoldCycles = 3000;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned DrainCycles    = 200;
  localparam int unsigned HoldPhase      = 2;
  // Saturation limits of the result fields
  localparam int unsigned TimeMax        = (1 << TimeW) - 1;
  localparam int unsigned SumMax         = (1 << SumW) - 1;

  // Values of order_mode
  localparam bit OrderLowFirst  = 1'b0;
  localparam bit OrderHighFirst = 1'b1;

  typedef struct {
    logic [TimeInW-1:0] arrival, burst;
    logic [PrioW-1:0]   prio;
    logic               last;
  } proc_beat_t;

  typedef struct {
    logic [IdxOutW-1:0] index;
    logic [TimeW-1:0]   waiting, turnaround;
    logic [SumW-1:0]    wait_total, turn_total;
    logic               last;
  } sched_result_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  psch_in_if  in_if ();
  psch_out_if out_if ();

  preemptive_priority_scheduler_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  always begin
    clk_i = 1'b1;
    #(ClkHighNs);
    clk_i = 1'b0;
    #(ClkLowNs);
  end

  // ---------------------------------------------------------------------------
  // Shared bench state
  // ---------------------------------------------------------------------------
  proc_beat_t    proc_beats_q[$];      // beats waiting for the driver
  sched_result_t sched_results_q[$];   // predicted results, oldest first
  int unsigned   beats_queued;
  int unsigned   beats_accepted;
  int unsigned   mismatch_cnt;
  bit            in_fire;              // input beat taken at the last rising edge
  bit            in_gaps_on;
  bit            out_gaps_on;
  int unsigned   in_gap;
  int unsigned   out_stall;
  int unsigned   hold_req_cnt;
  int unsigned   hold_served_cnt;

  // ---------------------------------------------------------------------------
  // Scheduler predictor: its own process table and its own copy of order_mode
  // ---------------------------------------------------------------------------
  logic [TimeInW-1:0] tbl_arrival [TableDepth];
  logic [TimeInW-1:0] tbl_burst   [TableDepth];
  logic [PrioW-1:0]   tbl_prio    [TableDepth];
  int unsigned        tbl_left    [TableDepth];
  bit                 tbl_done    [TableDepth];
  logic [TimeW-1:0]   tbl_wait    [TableDepth];
  logic [TimeW-1:0]   tbl_turn    [TableDepth];
  int unsigned        tbl_count;
  bit                 order_mode_q;

  function automatic int unsigned sat_add(int unsigned a, int unsigned b, int unsigned top);
    int unsigned s;
    s = a + b;
    return (s > top || s < a) ? top : s;
  endfunction

  // True if cand (scanned later) displaces held; equal arrival keeps the lower index.
  function automatic bit outranks(int unsigned cand, int unsigned held);
    if (tbl_prio[cand] != tbl_prio[held])
      return (order_mode_q == OrderHighFirst) ? (tbl_prio[cand] > tbl_prio[held])
                                              : (tbl_prio[cand] < tbl_prio[held]);
    return tbl_arrival[cand] < tbl_arrival[held];
  endfunction

  // Run the loaded set event by event, then queue one result per process in
  // load order and empty the table.
  function automatic void run_schedule();
    int unsigned   clock_now, finished, wsum, tsum, next_arr, slice, tat, wt;
    int            best;
    bit            have_next;
    sched_result_t res;
    clock_now = 0;
    finished  = 0;
    wsum      = 0;
    tsum      = 0;
    while (finished < tbl_count) begin
      best      = -1;
      have_next = 1'b0;
      next_arr  = 0;
      for (int i = 0; i < tbl_count; i++) begin
        if (tbl_done[i]) continue;
        if (tbl_arrival[i] <= clock_now) begin
          if (best < 0 || outranks(i, best)) best = i;
        end else if (!have_next || tbl_arrival[i] < next_arr) begin
          next_arr  = tbl_arrival[i];
          have_next = 1'b1;
        end
      end
      // Nothing ready: jump to the next arrival
      if (best < 0) begin
        clock_now = next_arr;
        continue;
      end
      // Run the winner until it finishes or the next arrival may preempt it
      slice = tbl_left[best];
      if (have_next && next_arr - clock_now < slice) slice = next_arr - clock_now;
      clock_now = sat_add(clock_now, slice, TimeMax);
      tbl_left[best] -= slice;
      if (tbl_left[best] == 0) begin
        tat = clock_now - tbl_arrival[best];
        wt  = (tat > tbl_burst[best]) ? tat - tbl_burst[best] : 0;
        tbl_turn[best] = tat[TimeW-1:0];
        tbl_wait[best] = wt[TimeW-1:0];
        wsum = sat_add(wsum, wt, SumMax);
        tsum = sat_add(tsum, tat, SumMax);
        tbl_done[best] = 1'b1;
        finished++;
      end
    end
    for (int i = 0; i < tbl_count; i++) begin
      res.index      = i[IdxOutW-1:0];
      res.waiting    = tbl_wait[i];
      res.turnaround = tbl_turn[i];
      res.last       = (i + 1 == tbl_count);
      res.wait_total = res.last ? wsum[SumW-1:0] : '0;
      res.turn_total = res.last ? tsum[SumW-1:0] : '0;
      sched_results_q.push_back(res);
    end
    tbl_count = 0;
    foreach (tbl_done[i]) tbl_done[i] = 1'b0;
  endfunction

  // Load one process beat; drop it once the table is full. The last flag
  // starts the schedule even when its own beat was dropped.
  function automatic void admit_process(proc_beat_t b);
    int unsigned burst;
    if (tbl_count < TableDepth) begin
      burst = (b.burst == 0) ? 1 : b.burst;  // zero burst runs as one unit
      tbl_arrival[tbl_count] = b.arrival;
      tbl_burst[tbl_count]   = burst[TimeInW-1:0];
      tbl_prio[tbl_count]    = b.prio;
      tbl_left[tbl_count]    = burst;
      tbl_done[tbl_count]    = 1'b0;
      tbl_count++;
    end
    if (b.last) run_schedule();
  endfunction

  // ---------------------------------------------------------------------------
  // Field checks
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Beat driver: change inputs on the falling edge, advance only on a taken beat
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : beat_driver
    proc_beat_t nxt;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_fire) begin
      if (in_gap != 0) begin
        in_gap--;
        in_if.valid <= 1'b0;
      end else if (proc_beats_q.size() != 0) begin
        nxt = proc_beats_q.pop_front();
        in_if.arrival_time   <= nxt.arrival;
        in_if.burst_time     <= nxt.burst;
        in_if.priority_level <= nxt.prio;
        in_if.last           <= nxt.last;
        in_if.valid          <= 1'b1;
        in_gap = in_gaps_on ? gap_len() : 0;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result ready: random stalls, plus a long hold-off on request so that the
  // block backs up into its input while the next set is being offered
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin : result_ready
    if (hold_req_cnt != hold_served_cnt) begin
      hold_served_cnt++;
      out_stall = LongHoldCycles;
    end
    if (out_stall != 0) begin
      out_stall--;
      out_if.ready <= 1'b0;
    end else if (!out_gaps_on || $urandom_range(0, 99) < 70) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= 1'b0;
      out_stall = gap_len();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels on the rising edge. Predict on every taken
  // input beat, then compare every taken result beat with the oldest prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : beat_monitor
    sched_result_t want;
    in_fire = ((rst_ni && in_if.valid && in_if.ready) === 1'b1);
    if (in_fire) begin
      admit_process('{arrival: in_if.arrival_time, burst: in_if.burst_time,
                      prio: in_if.priority_level, last: in_if.last});
      beats_accepted++;
    end
    if (rst_ni && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (sched_results_q.size() == 0) begin
        $error("result beat with nothing expected: process_index %0d",
               out_if.process_index);
        mismatch_cnt++;
      end else begin
        want = sched_results_q.pop_front();
        check_field("process_index",    want.index,      out_if.process_index);
        check_field("waiting_time",     want.waiting,    out_if.waiting_time);
        check_field("turnaround_time",  want.turnaround, out_if.turnaround_time);
        check_field("total_waiting",    want.wait_total, out_if.total_waiting);
        check_field("total_turnaround", want.turn_total, out_if.total_turnaround);
        check_field("last_res",         want.last,       out_if.last_res);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_beat(input logic [TimeInW-1:0] arrival, input logic [TimeInW-1:0] burst,
                           input logic [PrioW-1:0] prio, input logic last);
    proc_beats_q.push_back('{arrival: arrival, burst: burst, prio: prio, last: last});
    beats_queued++;
  endtask

  // Hold until every queued beat is taken and every predicted result is back,
  // then let the block settle before touching the register.
  task automatic wait_idle();
    while (beats_accepted != beats_queued || sched_results_q.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_order(input bit mode);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= mode;
    order_mode_q = mode;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly small sets, some up to a full table, and a few that overflow the table
  function automatic int unsigned set_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return $urandom_range(1, 4);
    if (r < 80) return $urandom_range(5, 10);
    if (r < 95) return $urandom_range(11, TableDepth);
    return $urandom_range(TableDepth + 1, TableDepth + 4);
  endfunction

  // One set with random content. Narrow arrival and priority spans keep the
  // processes competing, so preemption and both tie breaks come up often.
  task automatic queue_random_set(input int unsigned n);
    bit                 wide_arr;
    int unsigned        arr_span, prio_span, r;
    logic [TimeInW-1:0] arrival, burst;
    wide_arr  = ($urandom_range(0, 4) == 0);
    arr_span  = $urandom_range(0, 40);
    prio_span = $urandom_range(0, 1) ? 3 : 255;
    for (int i = 0; i < n; i++) begin
      arrival = wide_arr ? TimeInW'($urandom_range(0, 65535))
                         : TimeInW'($urandom_range(0, arr_span));
      r = $urandom_range(0, 99);
      if (r < 3)       burst = '0;
      else if (r < 88) burst = TimeInW'($urandom_range(1, 16));
      else             burst = TimeInW'($urandom_range(0, 65535));
      push_beat(arrival, burst, PrioW'($urandom_range(0, prio_span)), i == n - 1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned random_loaded, sets, n, phase_no;
    in_if.valid          = 1'b0;
    in_if.arrival_time   = '0;
    in_if.burst_time     = '0;
    in_if.priority_level = '0;
    in_if.last           = 1'b0;
    out_if.ready         = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_wdata_i          = 1'b0;
    rst_ni               = 1'b0;
    order_mode_q         = OrderLowFirst;
    in_gaps_on           = 1'b1;
    out_gaps_on          = 1'b1;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: low numbers win
    write_order(OrderLowFirst);
    // Single process, smallest fields
    push_beat(16'd0, 16'd1, 8'd0, 1'b1);
    // Field extremes, a zero burst, then ties broken by arrival
    // and by index
    push_beat(16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
    push_beat(16'd0,    16'd0,    8'h80, 1'b0);
    push_beat(16'd2,    16'd4,    8'h10, 1'b0);
    push_beat(16'd3,    16'd3,    8'h08, 1'b0);
    push_beat(16'd1,    16'd5,    8'h08, 1'b0);
    push_beat(16'd3,    16'd2,    8'h08, 1'b1);
    wait_idle();

    // Directed: high numbers win; every arrival preempts the runner, the
    // table fills and the closing beat is dropped yet still starts the run
    write_order(OrderHighFirst);
    for (int i = 0; i <= TableDepth; i++)
      push_beat(TimeInW'(i * 2), TimeInW'(5 + i % 3), PrioW'(i * 15), i == TableDepth);
    wait_idle();

    // Random phases; the register only moves while the block is idle
    random_loaded = 0;
    phase_no      = 0;
    while (random_loaded < RandomProcs) begin
      wait_idle();
      if (phase_no < 2)
        write_order(phase_no[0] ? OrderHighFirst : OrderLowFirst);
      else if ($urandom_range(0, 2) == 0)
        write_order($urandom_range(0, 1) ? OrderHighFirst : OrderLowFirst);
      in_gaps_on  = ($urandom_range(0, 3) != 0);
      out_gaps_on = ($urandom_range(0, 3) != 0);
      sets = $urandom_range(1, 6);
      if (phase_no == HoldPhase) begin
        // Back-pressure: stall the results while the sender keeps offering
        sets       = 3;
        in_gaps_on = 1'b0;
        hold_req_cnt++;
      end
      repeat (sets) begin
        n = set_size();
        queue_random_set(n);
        random_loaded += (n > TableDepth) ? TableDepth : n;
      end
      phase_no++;
    end

    wait_idle();
    // Watch for stray result beats
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0)
      $display("tb_preemptive_priority_scheduler_core passed");
    else
      $display("tb_preemptive_priority_scheduler_core failed");
    $finish;
  end

  // Hard stop if the block hangs
  initial begin : watchdog
    #(WatchdogNs);
    $display("tb_preemptive_priority_scheduler_core failed");
    $finish;
  end

endmodule

// ----- preemptive_priority_scheduler_core.f -----
rtl/core/psch_pkg.sv
rtl/core/psch_in_if.sv
rtl/core/psch_out_if.sv
rtl/core/psch_ram.sv
rtl/core/psch_scan.sv
rtl/core/preemptive_priority_scheduler_core.sv
sim/tb_preemptive_priority_scheduler_core.sv
